// ===== design/ordered_array_insert_delete_search_top_defines.svh =====
// Assertion helpers for the top design file.
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OAIDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OAIDS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/oaids_pkg.sv =====
package oaids_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned IDX_W      = 7;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_DELETE,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] found_index;
    } t_result;

endpackage

// ===== design/ordered_array_insert_delete_search_top.sv =====
// Channel   Dir  tdata (low bit up)                  tuser
// s_axis    in   value[31:0], position[39:32]        command[1:0]
// m_axis    out  found_index[6:0], count[14:7], 0    status[2:0]
//
// One command is worked at a time, with at most one read and one write of the store per cycle.
// Insert and delete shift the entries between the position and the end of the store one place,
// search walks up from entry 0 until it finds the value or reaches the count, and the result
// word is then loaded. A refused command or an unused code goes straight to the result word.
// i_rst_n (synchronous) clears the count and control; the store itself is not cleared.
// A result word held by a stalled m_axis does not stop the next command from being taken.
`include "ordered_array_insert_delete_search_top_defines.svh"

module ordered_array_insert_delete_search_top #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // value[31:0], position[39:32]
    input  logic [oaids_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // command[1:0]
    input  logic [oaids_pkg::CMD_W-1:0]          i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // found_index[6:0], count[14:7], zero pad
    output logic [oaids_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // status[2:0]
    output logic [oaids_pkg::STATUS_W-1:0]       o_m_axis_tuser
);

    localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > oaids_pkg::POS_W) ? CW : oaids_pkg::POS_W;

    oaids_pkg::t_state  r_state, n_state;
    oaids_pkg::t_result r_res, n_res;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_pos;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic [oaids_pkg::VALUE_W-1:0] r_value;
    logic               r_ovalid, n_ovalid;
    logic [oaids_pkg::OUT_DATA_W-1:0] r_odata;
    logic [oaids_pkg::STATUS_W-1:0]   r_ouser;

    logic [oaids_pkg::VALUE_W-1:0] r_mem [CAPACITY];
    logic [oaids_pkg::VALUE_W-1:0] r_rd_data;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          we;
    logic [AW-1:0]                 wa;
    logic [oaids_pkg::VALUE_W-1:0] wd;

    oaids_pkg::t_cmd               in_cmd;
    logic [oaids_pkg::VALUE_W-1:0] in_value;
    logic [oaids_pkg::POS_W-1:0]   in_pos;
    logic [CMPW-1:0]               pos_ext, cnt_ext;
    logic                          s_accept, out_free, load_out;
    logic                          ins_full, ins_badpos, del_empty, del_badpos;
    logic [CW-1:0]                 k_plus1, k_minus1;
    logic                          ins_last, del_last, srch_hit, srch_miss;

    assign in_cmd   = oaids_pkg::t_cmd'(i_s_axis_tuser);
    assign in_value = i_s_axis_tdata[oaids_pkg::VALUE_W-1:0];
    assign in_pos   = i_s_axis_tdata[oaids_pkg::IN_DATA_W-1:oaids_pkg::VALUE_W];
    assign pos_ext  = CMPW'(in_pos);
    assign cnt_ext  = CMPW'(r_count);

    assign o_s_axis_tready = (r_state == oaids_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign load_out        = (r_state == oaids_pkg::S_DONE) && out_free;

    assign ins_full   = (r_count == CW'(CAPACITY));
    assign ins_badpos = (pos_ext > cnt_ext);
    assign del_empty  = (r_count == '0);
    assign del_badpos = (pos_ext >= cnt_ext);

    assign k_plus1  = r_k + 1'b1;
    assign k_minus1 = r_k - 1'b1;

    // A walk ends once no read is in flight and the cursor has reached its bound, or on a search hit.
    assign ins_last  = !r_pend && (r_k == r_pos);
    assign del_last  = !r_pend && (k_plus1 >= r_count);
    assign srch_hit  = r_pend && (r_rd_data == r_value);
    assign srch_miss = !r_pend && (r_k >= r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            oaids_pkg::S_IDLE: begin
                if (s_accept) begin
                    case (in_cmd)
                        oaids_pkg::CMD_INSERT: begin
                            n_state = (ins_full || ins_badpos) ? oaids_pkg::S_DONE
                                                               : oaids_pkg::S_INSERT;
                        end
                        oaids_pkg::CMD_DELETE: begin
                            n_state = (del_empty || del_badpos) ? oaids_pkg::S_DONE
                                                                : oaids_pkg::S_DELETE;
                        end
                        oaids_pkg::CMD_SEARCH: n_state = oaids_pkg::S_SEARCH;
                        default:               n_state = oaids_pkg::S_DONE;
                    endcase
                end
            end
            oaids_pkg::S_INSERT: if (ins_last) n_state = oaids_pkg::S_DONE;
            oaids_pkg::S_DELETE: if (del_last) n_state = oaids_pkg::S_DONE;
            oaids_pkg::S_SEARCH: if (srch_hit || srch_miss) n_state = oaids_pkg::S_DONE;
            oaids_pkg::S_DONE:   if (out_free) n_state = oaids_pkg::S_IDLE;
            default:             n_state = oaids_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_k      = r_k;
        n_pend   = 1'b0;
        n_waddr  = r_waddr;
        n_res    = r_res;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        rd_en    = 1'b0;
        rd_addr  = r_k[AW-1:0];
        we       = 1'b0;
        wa       = r_waddr;
        wd       = r_rd_data;
        case (r_state)
            oaids_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_res.found_index = '0;
                    n_res.status      = oaids_pkg::ST_OK;
                    case (in_cmd)
                        oaids_pkg::CMD_INSERT: begin
                            n_k = r_count;
                            if (ins_full) begin
                                n_res.status = oaids_pkg::ST_FULL;
                            end else if (ins_badpos) begin
                                n_res.status = oaids_pkg::ST_BADPOS;
                            end
                        end
                        oaids_pkg::CMD_DELETE: begin
                            n_k = CW'(in_pos);
                            if (del_empty) begin
                                n_res.status = oaids_pkg::ST_EMPTY;
                            end else if (del_badpos) begin
                                n_res.status = oaids_pkg::ST_BADPOS;
                            end
                        end
                        oaids_pkg::CMD_SEARCH: n_k = '0;
                        default:               n_k = r_k;
                    endcase
                end
            end
            oaids_pkg::S_INSERT: begin
                // Read entry k-1 and write it one place up in the next cycle.
                if (r_pend) begin
                    we = 1'b1;
                end
                if (r_k != r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = k_minus1[AW-1:0];
                    n_pend  = 1'b1;
                    n_waddr = r_k[AW-1:0];
                    n_k     = k_minus1;
                end else if (!r_pend) begin
                    we      = 1'b1;
                    wa      = r_pos[AW-1:0];
                    wd      = r_value;
                    n_count = r_count + 1'b1;
                end
            end
            oaids_pkg::S_DELETE: begin
                // Read entry k+1 and write it one place down in the next cycle.
                if (r_pend) begin
                    we = 1'b1;
                end
                if (k_plus1 < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = k_plus1[AW-1:0];
                    n_pend  = 1'b1;
                    n_waddr = r_k[AW-1:0];
                    n_k     = k_plus1;
                end else if (!r_pend) begin
                    n_count = r_count - 1'b1;
                end
            end
            oaids_pkg::S_SEARCH: begin
                if (srch_hit) begin
                    n_res.status      = oaids_pkg::ST_OK;
                    n_res.found_index = oaids_pkg::IDX_W'(r_waddr);
                end else if (srch_miss) begin
                    n_res.status = oaids_pkg::ST_NOTFOUND;
                end else if (r_k < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_k[AW-1:0];
                    n_pend  = 1'b1;
                    n_waddr = r_k[AW-1:0];
                    n_k     = k_plus1;
                end
            end
            oaids_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= oaids_pkg::S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_waddr <= n_waddr;
        r_res   <= n_res;
        if (s_accept) begin
            r_value <= in_value;
            r_pos   <= CW'(in_pos);
        end
        if (load_out) begin
            r_odata <= oaids_pkg::OUT_DATA_W'({oaids_pkg::COUNT_W'(r_count),
                                               r_res.found_index});
            r_ouser <= r_res.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `OAIDS_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `OAIDS_ASSERT_IMP(a_write_state, i_clk, i_rst_n, we, (r_state == oaids_pkg::S_INSERT) || (r_state == oaids_pkg::S_DELETE), "store written outside a shift walk")
    `OAIDS_ASSERT_IMP(a_read_below_count, i_clk, i_rst_n, rd_en, CW'(rd_addr) < r_count, "read beyond the filled entries")
    `OAIDS_ASSERT_NXT(a_insert_grows, i_clk, i_rst_n, (r_state == oaids_pkg::S_INSERT) && ins_last, r_count == CW'($past(r_count) + 1'b1), "insert did not grow the count")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import oaids_pkg::*;

    localparam int unsigned DEPTH = 128;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } reply_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata;   // value[31:0], position[39:32]
    logic [CMD_W-1:0]        i_s_axis_tuser;   // command[1:0]
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;   // found_index[6:0], count[14:7], zero pad
    logic [STATUS_W-1:0]     o_m_axis_tuser;   // status[2:0]

    // Mirror of the word store and its fill count.
    logic [VALUE_W-1:0] words [DEPTH];
    int unsigned        held;
    reply_t             awaited_replies [$];
    int unsigned        errors;
    int unsigned        cycles;
    bit                 steady;

    ordered_array_insert_delete_search_top #(
        .CAPACITY(DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, none while steady is set.
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // Applies one command to the mirror and queues the reply it must produce.
    function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] val,
                                          input logic [POS_W-1:0] pos);
        reply_t      r;
        int unsigned k;
        bit          hit;
        r.status = ST_OK;
        r.index  = '0;
        hit      = 1'b0;
        case (cmd)
            CMD_INSERT: begin
                if (held == DEPTH) begin
                    r.status = ST_FULL;
                end else if (pos > held) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = held; k > pos; k--)
                        words[k] = words[k-1];
                    words[pos] = val;
                    held++;
                end
            end
            CMD_DELETE: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= held) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = pos; k + 1 < held; k++)
                        words[k] = words[k+1];
                    held--;
                end
            end
            CMD_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (k = 0; k < held; k++) begin
                    if (!hit && words[k] == val) begin
                        hit      = 1'b1;
                        r.status = ST_OK;
                        r.index  = k[IDX_W-1:0];
                    end
                end
            end
            default: r.status = ST_OK;
        endcase
        r.count = held[COUNT_W-1:0];
        awaited_replies.push_back(r);
    endfunction

    // Called and left at a falling edge; the word is predicted once it is taken.
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [VALUE_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = gap_length();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = {pos, val};
        i_s_axis_tuser  = cmd;
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        apply_command(cmd, val, pos);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_replies();
        while (awaited_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Result side: random stalls on the master handshake.
    initial begin
        int unsigned stall;
        stall = 0;
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                stall--;
            end else begin
                i_m_axis_tready = 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall = gap_length();
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        reply_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                $error("reply word with none expected: tdata %h tuser %0d",
                       o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_m_axis_tuser != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata[6:0] != want.index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.index, o_m_axis_tdata[6:0]);
                    errors++;
                end
                if (o_m_axis_tdata[14:7] != want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_m_axis_tdata[14:7]);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        issue_command(CMD_SEARCH, 32'h0000_0000, 8'd0);      // search while empty
        issue_command(CMD_DELETE, 32'h0000_0000, 8'd0);      // delete while empty
        issue_command(CMD_DELETE, 32'hFFFF_FFFF, 8'd255);    // empty wins over bad position
        issue_command(CMD_INSERT, 32'h1234_5678, 8'd1);      // past the end of an empty store
        issue_command(CMD_INSERT, 32'h8000_0000, 8'd0);
        issue_command(CMD_INSERT, 32'h7FFF_FFFF, 8'd1);      // append
        issue_command(CMD_INSERT, 32'h0000_0000, 8'd1);      // middle
        issue_command(CMD_INSERT, 32'hFFFF_FFFF, 8'd0);      // front
        issue_command(CMD_INSERT, 32'h7FFF_FFFF, 8'd2);      // duplicate ahead of the first
        issue_command(CMD_INSERT, 32'h5555_AAAA, 8'd6);      // one past the end
        issue_command(CMD_INSERT, 32'hAAAA_5555, 8'd255);
        issue_command(CMD_SEARCH, 32'h7FFF_FFFF, 8'd255);    // lowest of two matches
        issue_command(CMD_SEARCH, 32'h8000_0000, 8'd0);
        issue_command(CMD_SEARCH, 32'hFFFF_FFFF, 8'd0);
        issue_command(CMD_SEARCH, 32'h0001_E240, 8'd0);
        issue_command(CMD_DELETE, 32'h0000_0000, 8'd5);      // position equal to the count
        issue_command(CMD_DELETE, 32'h0000_0000, 8'd255);
        issue_command(CMD_UNUSED, 32'hFFFF_FFFF, 8'd255);
        issue_command(CMD_DELETE, 32'h0000_0000, 8'd4);      // last entry
        issue_command(CMD_DELETE, 32'h0000_0000, 8'd0);      // first entry
        issue_command(CMD_DELETE, 32'h0000_0000, 8'd1);      // middle entry
        issue_command(CMD_SEARCH, 32'h8000_0000, 8'd0);
        issue_command(CMD_SEARCH, 32'h7FFF_FFFF, 8'd0);
    endtask

    task automatic test_fill_and_drain();
        while (held < DEPTH)
            issue_command(CMD_INSERT, $urandom, 8'($urandom_range(0, held)));
        issue_command(CMD_INSERT, $urandom, 8'd255);         // full wins over bad position
        issue_command(CMD_INSERT, $urandom, 8'd0);
        issue_command(CMD_SEARCH, words[DEPTH-1], 8'd0);
        issue_command(CMD_UNUSED, 32'h0000_0000, 8'd0);
        // Hold the sender until the store is quiet before emptying it.
        wait_replies();
        while (held > 0)
            issue_command(CMD_DELETE, $urandom, 8'($urandom_range(0, held - 1)));
        issue_command(CMD_DELETE, $urandom, 8'($urandom));
        issue_command(CMD_SEARCH, $urandom, 8'($urandom));
    endtask

    task automatic test_random_mix();
        int unsigned blk;
        int unsigned n;
        int unsigned r;
        int unsigned ins_share;
        logic [VALUE_W-1:0] val;
        for (blk = 0; blk < 10; blk++) begin
            // Alternate between growing and shrinking so the count sweeps its range.
            ins_share = blk[0] ? 30 : 60;
            steady = (blk == 7 || blk == 8);
            for (n = 0; n < 100; n++) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 1))
                    val = $urandom;
                else
                    val = 32'($urandom_range(0, 15)) - 32'd8;
                if (r < 5) begin
                    issue_command(2'($urandom), $urandom, 8'($urandom));
                end else if (r < 5 + ins_share) begin
                    issue_command(CMD_INSERT, val, 8'($urandom_range(0, held + 1)));
                end else if (r < 75) begin
                    issue_command(CMD_DELETE, val,
                                  8'($urandom_range(0, (held == 0) ? 1 : held)));
                end else begin
                    if (held > 0 && $urandom_range(0, 9) < 7)
                        val = words[$urandom_range(0, held - 1)];
                    issue_command(CMD_SEARCH, val, 8'($urandom));
                end
            end
            if (blk == 4)
                wait_replies();
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        held            = 0;
        errors          = 0;
        cycles          = 0;
        steady          = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_mix();

        wait_replies();
        repeat (DEPTH + 16) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
